>>> rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Types and constants shared by the length-prefix deframer modules.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 32;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [LenW-1:0] MaxBodyLengthReset = 32'h0010_0000;

  typedef enum logic [0:0] {
    REG_MAX_BODY_LENGTH = 1'b0
  } lpd_reg_idx_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ZERO = 2'd1,
    STATUS_OVER = 2'd2
  } lpd_status_t;

  localparam logic [1:0] HdrIdxLast = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } lpd_stage_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_body;
    logic             body_last;
    logic             header_done;
    logic [LenW-1:0]  body_length;
    lpd_status_t      status;
  } lpd_result_t;

endpackage

>>> rtl/lpd_stream_if.sv
// ----------------------------------------------------------------------------
// lpd_byte_if / lpd_result_if
// Valid/ready channels for the raw byte stream and the deframed results.
// ----------------------------------------------------------------------------
interface lpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lpd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_body;
  logic        body_last;
  logic        header_done;
  logic [31:0] body_length;
  logic [1:0]  status;

  modport source (output valid, output out_byte, output is_body, output body_last,
                  output header_done, output body_length, output status, input ready);
  modport sink   (input valid, input out_byte, input is_body, input body_last,
                  input header_done, input body_length, input status, output ready);
endinterface

>>> rtl/length_prefix_deframer.sv
// ----------------------------------------------------------------------------
// length_prefix_deframer
// Splits a byte stream into frames with a 4-byte big-endian length header.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transaction
//  in_ch    sink       one raw stream byte
//  out_ch   source     one result per byte: byte, body flags, header length, status
//  cfg      APB slave  write/read of max_body_length at address 0
//
// Each byte passes from acceptance to result through the input register and
// then the result register, giving a throughput of one byte per clock while
// the consumer does not stall; the frame state updates with the result register.
// A result held by a stalled consumer still lets one more byte enter the input
// register. Reset is synchronous and clears the frame state and both stages.
// ----------------------------------------------------------------------------
module length_prefix_deframer
  import lpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  lpd_byte_if.sink            in_ch,
  lpd_result_if.source        out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic [LenW-1:0] max_body_length;
  logic            advance;
  lpd_stage_t      stage;
  lpd_result_t     result;

  lpd_cfg_regs u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .max_body_length (max_body_length)
  );

  lpd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.in_byte),
    .in_ready (in_ch.ready),
    .advance  (advance),
    .stage    (stage)
  );

  lpd_frame_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .stage           (stage),
    .max_body_length (max_body_length),
    .advance         (advance),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .result          (result)
  );

  assign out_ch.out_byte    = result.out_byte;
  assign out_ch.is_body     = result.is_body;
  assign out_ch.body_last   = result.body_last;
  assign out_ch.header_done = result.header_done;
  assign out_ch.body_length = result.body_length;
  assign out_ch.status      = result.status;

  a_status_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != STATUS_OK) |-> out_ch.header_done)
    else $error("Rejection status reported without a completed header.");

  a_body_not_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_body |-> !out_ch.header_done && (out_ch.body_length == '0))
    else $error("Body byte also flagged as a header byte.");

  a_last_is_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.body_last |-> out_ch.is_body)
    else $error("Last-byte flag on a header byte.");

  a_stall_only_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("Input stalled while the result register is free.");

endmodule

>>> rtl/lpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// lpd_cfg_regs
// APB-style register file holding the body length limit.
// ----------------------------------------------------------------------------
module lpd_cfg_regs
  import lpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output logic [LenW-1:0]     max_body_length
);

  logic [LenW-1:0] max_len_r;
  logic [LenW-1:0] max_len_nxt;
  logic            reg_hit;
  logic            wr_en;

  assign pready  = 1'b1;
  assign reg_hit = (lpd_reg_idx_t'(paddr[2]) == REG_MAX_BODY_LENGTH);
  assign wr_en   = psel && penable && pwrite && pready && reg_hit;

  always_comb begin
    max_len_nxt = max_len_r;
    if (wr_en) begin
      max_len_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MaxBodyLengthReset;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  assign prdata          = reg_hit ? max_len_r : '0;
  assign max_body_length = max_len_r;

endmodule

>>> rtl/lpd_in_stage.sv
// ----------------------------------------------------------------------------
// lpd_in_stage
// Input register that captures one byte transaction per cycle while in_ready is high.
// ----------------------------------------------------------------------------
module lpd_in_stage
  import lpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [ByteW-1:0] in_byte,
  output logic             in_ready,
  input  logic             advance,
  output lpd_stage_t       stage
);

  logic             valid_r;
  logic             valid_nxt;
  logic [ByteW-1:0] data_r;
  logic             take;

  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_byte;
    end
  end

  assign stage.valid = valid_r;
  assign stage.data  = data_r;

endmodule

>>> rtl/lpd_frame_core.sv
// ----------------------------------------------------------------------------
// lpd_frame_core
// Frame state, per-byte classification and the result register.
// ----------------------------------------------------------------------------
module lpd_frame_core
  import lpd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  lpd_stage_t      stage,
  input  logic [LenW-1:0] max_body_length,
  output logic            advance,
  output logic            out_valid,
  input  logic            out_ready,
  output lpd_result_t     result
);

  logic            in_body_r, in_body_nxt;
  logic [1:0]      hdr_idx_r, hdr_idx_nxt;
  logic [LenW-1:0] accum_r, accum_nxt;
  logic [LenW-1:0] left_r, left_nxt;
  logic            out_valid_r, out_valid_nxt;
  lpd_result_t     res_r, res_nxt;
  logic [LenW-1:0] left_dec;

  assign advance  = stage.valid && (!out_valid_r || out_ready);
  assign left_dec = (left_r != '0) ? left_r - 1'b1 : '0;

  always_comb begin
    in_body_nxt = in_body_r;
    hdr_idx_nxt = hdr_idx_r;
    accum_nxt   = accum_r;
    left_nxt    = left_r;
    res_nxt     = '{out_byte: stage.data, is_body: 1'b0, body_last: 1'b0,
                    header_done: 1'b0, body_length: '0, status: STATUS_OK};
    if (in_body_r) begin
      res_nxt.is_body = 1'b1;
      left_nxt        = left_dec;
      if (left_dec == '0) begin
        res_nxt.body_last = 1'b1;
        in_body_nxt       = 1'b0;
      end
    end else begin
      accum_nxt = (hdr_idx_r == 2'd0) ? {{(LenW-ByteW){1'b0}}, stage.data}
                                      : {accum_r[LenW-ByteW-1:0], stage.data};
      if (hdr_idx_r == HdrIdxLast) begin
        res_nxt.header_done = 1'b1;
        res_nxt.body_length = accum_nxt;
        hdr_idx_nxt         = 2'd0;
        priority if (accum_nxt == '0) begin
          res_nxt.status = STATUS_ZERO;
        end else if (accum_nxt > max_body_length) begin
          res_nxt.status = STATUS_OVER;
        end else begin
          in_body_nxt = 1'b1;
          left_nxt    = accum_nxt;
        end
      end else begin
        hdr_idx_nxt = hdr_idx_r + 2'd1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r   <= 1'b0;
      hdr_idx_r   <= 2'd0;
      accum_r     <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        in_body_r <= in_body_nxt;
        hdr_idx_r <= hdr_idx_nxt;
        accum_r   <= accum_nxt;
        left_r    <= left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

endmodule
